// File: rtl/core/rhm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhm_pkg
// Shared constants, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package rhm_pkg;

    localparam int MAX_ENTRIES = 64;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = IDX_W + 1;
    localparam int LOG_W       = 4;
    localparam int DATA_W      = 32;
    localparam int BKT_W       = 6;

    localparam logic [LOG_W-1:0]  MIN_LOG2 = LOG_W'(3);
    localparam logic [LOG_W-1:0]  MAX_LOG2 = LOG_W'(IDX_W);
    localparam logic [DATA_W-1:0] GOLDEN   = 32'h9E37_79B9;

    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_REMOVE = 2'd1;
    localparam logic [1:0] ACT_GET    = 2'd2;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_DUP     = 2'd1;
    localparam logic [1:0] ST_MISSING = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    typedef struct packed {
        logic load;
        logic scan;
        logic exec;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic scan_last;
        logic out_free;
    } stat_t;

    function automatic logic [CNT_W-1:0] pow2(input logic [LOG_W-1:0] l);
        pow2 = CNT_W'(1) << l;
    endfunction

endpackage

// File: rtl/core/rhm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhm_ctrl
// Request sequencer: accept, table scan, update, result hand-off.
// ----------------------------------------------------------------------------
module rhm_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  rhm_pkg::stat_t stat,
    output rhm_pkg::cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_EXEC,
        S_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        s_tready     = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                cmd.scan = 1'b1;
                if (stat.scan_last) begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN: begin
                state_next = S_EXEC;
            end
            S_EXEC: begin
                cmd.exec   = 1'b1;
                state_next = S_FINISH;
            end
            S_FINISH: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// File: rtl/core/rhm_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhm_dp
// Entry storage, key scan comparator, counters, hash and result register.
// ----------------------------------------------------------------------------
module rhm_dp (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  rhm_pkg::cmd_t                   cmd,
    output rhm_pkg::stat_t                  stat,
    input  logic [1:0]                      in_action,
    input  logic [rhm_pkg::DATA_W-1:0]      in_key,
    input  logic [rhm_pkg::DATA_W-1:0]      in_value,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [1:0]                      out_status,
    output logic [rhm_pkg::DATA_W-1:0]      out_read_value,
    output logic [rhm_pkg::BKT_W-1:0]       out_bucket_index,
    output logic [rhm_pkg::CNT_W-1:0]       out_bucket_count,
    output logic [rhm_pkg::CNT_W-1:0]       out_entry_count
);

    logic [rhm_pkg::DATA_W-1:0] key_mem [rhm_pkg::MAX_ENTRIES];
    logic [rhm_pkg::DATA_W-1:0] val_mem [rhm_pkg::MAX_ENTRIES];
    logic [rhm_pkg::MAX_ENTRIES-1:0] valid_reg;

    logic [1:0]                 act_reg;
    logic [rhm_pkg::DATA_W-1:0] key_reg;
    logic [rhm_pkg::DATA_W-1:0] val_reg;
    logic [rhm_pkg::DATA_W-1:0] hash_reg;
    logic [rhm_pkg::LOG_W-1:0]  log2_reg;
    logic [rhm_pkg::CNT_W-1:0]  count_reg;
    logic [1:0]                 status_reg;

    logic [rhm_pkg::IDX_W-1:0]  addr_reg;
    logic [rhm_pkg::IDX_W-1:0]  cidx_reg;
    logic                       cv_reg;
    logic [rhm_pkg::DATA_W-1:0] keyq_reg;
    logic [rhm_pkg::DATA_W-1:0] valq_reg;
    logic                       hit_reg;
    logic [rhm_pkg::IDX_W-1:0]  slot_reg;
    logic                       free_reg;
    logic [rhm_pkg::IDX_W-1:0]  fidx_reg;

    logic                       m_valid_reg;
    logic [1:0]                 o_status_reg;
    logic [rhm_pkg::DATA_W-1:0] o_rd_reg;
    logic [rhm_pkg::BKT_W-1:0]  o_bkt_reg;
    logic [rhm_pkg::CNT_W-1:0]  o_bcnt_reg;
    logic [rhm_pkg::CNT_W-1:0]  o_ecnt_reg;

    logic [rhm_pkg::CNT_W-1:0]  cap;
    logic                       ins_ok;
    logic [rhm_pkg::CNT_W-1:0]  cnt_dec;
    logic [5:0]                 shamt;
    logic [rhm_pkg::DATA_W-1:0] hash_sh;

    assign cap     = rhm_pkg::pow2(log2_reg);
    assign ins_ok  = !hit_reg && (count_reg < cap)
                     && (count_reg < rhm_pkg::CNT_W'(rhm_pkg::MAX_ENTRIES));
    assign cnt_dec = (hit_reg && count_reg != '0) ? count_reg - 1'b1 : count_reg;
    assign shamt   = 6'd32 - 6'(log2_reg);
    assign hash_sh = hash_reg >> shamt;

    assign stat.scan_last = (addr_reg == rhm_pkg::IDX_W'(rhm_pkg::MAX_ENTRIES - 1));
    assign stat.out_free  = !m_valid_reg || m_tready;

    // memories
    always_ff @(posedge aclk) begin
        keyq_reg <= key_mem[addr_reg];
        valq_reg <= val_mem[slot_reg];
        if (cmd.exec && act_reg == rhm_pkg::ACT_INSERT && ins_ok) begin
            key_mem[fidx_reg] <= key_reg;
            val_mem[fidx_reg] <= val_reg;
        end
    end

    // request registers and hash
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            act_reg  <= in_action;
            key_reg  <= in_key;
            val_reg  <= in_value;
            hash_reg <= in_key * rhm_pkg::GOLDEN;
        end
    end

    // scan pipeline
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            addr_reg <= '0;
            cv_reg   <= 1'b0;
            hit_reg  <= 1'b0;
            free_reg <= 1'b0;
        end else begin
            cv_reg <= cmd.scan;
            if (cmd.load) begin
                addr_reg <= '0;
                hit_reg  <= 1'b0;
                free_reg <= 1'b0;
            end else if (cmd.scan) begin
                addr_reg <= addr_reg + 1'b1;
            end
            cidx_reg <= addr_reg;
            if (cv_reg) begin
                if (valid_reg[cidx_reg] && keyq_reg == key_reg && !hit_reg) begin
                    hit_reg  <= 1'b1;
                    slot_reg <= cidx_reg;
                end
                if (!valid_reg[cidx_reg] && !free_reg) begin
                    free_reg <= 1'b1;
                    fidx_reg <= cidx_reg;
                end
            end
        end
    end

    // table state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            count_reg <= '0;
            log2_reg  <= rhm_pkg::MIN_LOG2;
        end else begin
            if (cmd.load && in_action == rhm_pkg::ACT_INSERT
                    && count_reg >= cap && log2_reg < rhm_pkg::MAX_LOG2) begin
                log2_reg <= log2_reg + 1'b1;
            end
            if (cmd.exec) begin
                if (act_reg == rhm_pkg::ACT_INSERT) begin
                    if (ins_ok) begin
                        valid_reg[fidx_reg] <= 1'b1;
                        count_reg           <= count_reg + 1'b1;
                    end
                end else if (act_reg == rhm_pkg::ACT_REMOVE) begin
                    if (hit_reg) begin
                        valid_reg[slot_reg] <= 1'b0;
                    end
                    count_reg <= cnt_dec;
                    if ({cnt_dec, 2'b00} <= {2'b00, cap} && log2_reg > rhm_pkg::MIN_LOG2) begin
                        log2_reg <= log2_reg - 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            if (act_reg == rhm_pkg::ACT_INSERT) begin
                status_reg <= hit_reg ? rhm_pkg::ST_DUP
                            : (ins_ok ? rhm_pkg::ST_DONE : rhm_pkg::ST_FULL);
            end else begin
                status_reg <= hit_reg ? rhm_pkg::ST_DONE : rhm_pkg::ST_MISSING;
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            o_status_reg <= status_reg;
            o_rd_reg     <= (act_reg != rhm_pkg::ACT_INSERT && act_reg != rhm_pkg::ACT_REMOVE
                             && hit_reg) ? valq_reg : '0;
            o_bkt_reg    <= hash_sh[rhm_pkg::BKT_W-1:0];
            o_bcnt_reg   <= cap;
            o_ecnt_reg   <= count_reg;
        end
    end

    assign m_tvalid         = m_valid_reg;
    assign out_status       = o_status_reg;
    assign out_read_value   = o_rd_reg;
    assign out_bucket_index = o_bkt_reg;
    assign out_bucket_count = o_bcnt_reg;
    assign out_entry_count  = o_ecnt_reg;

endmodule

// File: rtl/core/resizing_hash_map.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// resizing_hash_map
// Key-value map of up to 64 entries with a growing/shrinking bucket count.
// ----------------------------------------------------------------------------
// Usage:
//   s_ side takes one request (action, key, value) per handshake; action is
//   insert, remove or get. m_ side returns one result per request: status,
//   read value, bucket index, bucket count and entry count.
//   Each request passes from accept to result through a load, a scan of
//   all 64 entries of the key store through a single comparator (one
//   entry per cycle, set by the single read port of the key memory), a
//   drain, an update and a result load. Requests are handled one at a
//   time; s_tready is high only while the block is idle.
//   The result sits in an output register, so a new request is accepted
//   while the previous result waits; a stalled m_tready holds the result
//   and delays only the hand-off of the following one.
//   Reset clears all entry valid bits, the entry count, and sets the
//   bucket count to 8. Key/value memories are not cleared.
// ----------------------------------------------------------------------------
module resizing_hash_map (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,  // action[1:0], key[33:2], value[65:34]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata   // status[1:0], read_value[33:2],
                                  // bucket_index[39:34], bucket_count[46:40],
                                  // entry_count[53:47]
);

    rhm_pkg::cmd_t  cmd;
    rhm_pkg::stat_t stat;

    logic [1:0]                     out_status;
    logic [rhm_pkg::DATA_W-1:0]     out_read_value;
    logic [rhm_pkg::BKT_W-1:0]      out_bucket_index;
    logic [rhm_pkg::CNT_W-1:0]      out_bucket_count;
    logic [rhm_pkg::CNT_W-1:0]      out_entry_count;

    rhm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    rhm_dp u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .stat             (stat),
        .in_action        (s_tdata[1:0]),
        .in_key           (s_tdata[33:2]),
        .in_value         (s_tdata[65:34]),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .out_status       (out_status),
        .out_read_value   (out_read_value),
        .out_bucket_index (out_bucket_index),
        .out_bucket_count (out_bucket_count),
        .out_entry_count  (out_entry_count)
    );

    assign m_tdata = {2'b00, out_entry_count, out_bucket_count, out_bucket_index,
                      out_read_value, out_status};

endmodule

// File: rtl/core/rhm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhm_checker
// Port-level checks on the result stream of the map.
// ----------------------------------------------------------------------------
module rhm_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_bcount: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> $onehot(m_tdata[46:40]) && m_tdata[42:40] == 3'b000)
        else $error("bucket count not a power of two of at least 8");

    a_ecount: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[53:47] <= m_tdata[46:40])
        else $error("entry count above bucket count");

    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while previous one in progress");

endmodule

bind resizing_hash_map rhm_checker u_rhm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
